// ----- rtl/free_list_pool_allocator_assert.svh -----
// Assertion macros for the free-list pool allocator.
`ifndef FREE_LIST_POOL_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define FLA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fla assertion failed");
`define FLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fla assertion failed");
`else
`define FLA_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/fla_pkg.sv -----
// Shared constants and codes for the free-list pool allocator.
package fla_pkg;
  localparam int POOL_BYTES_DEF   = 65536;
  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int MAX_RECORDS_DEF  = 32;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int NODE_BYTES_DEF   = 16;
  localparam int MIN_ALIGN_LOG2   = 3;
  localparam int MAX_ALIGN_LOG2   = 12;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_BAD     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
endpackage

// ----- rtl/fla_if.sv -----
// Channel interfaces: request, result and configuration write.
interface fla_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] request_size;
  logic [3:0]  align_log2;
  logic [15:0] data_address;
  modport source (output valid, opcode, request_size, align_log2, data_address, input ready);
  modport sink (input valid, opcode, request_size, align_log2, data_address, output ready);
endinterface

interface fla_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] result_address;
  logic [16:0] used_bytes;
  logic [16:0] peak_bytes;
  modport source (output valid, status, result_address, used_bytes, peak_bytes, input ready);
  modport sink (input valid, status, result_address, used_bytes, peak_bytes, output ready);
endinterface

interface fla_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/free_list_pool_allocator.sv -----
// Free-list pool allocator: one request at a time, tables walked one entry a cycle.
//
// Keeps the free space of a pool as an address-sorted table of free segments and each live
// allocation as a record (data address, length with padding, padding). An allocate walks the
// segment table with one shared fit evaluator, first fit or best fit per policy_r, then
// splits or removes the chosen segment. A free walks the records for the address, walks the
// segments for the insert position and merges with either neighbor, shifting the table one
// entry a cycle where an entry is removed or inserted. Every request gives one result with
// used and peak byte totals. The segment table has one read port, so table steps go one entry
// a cycle. in_ch.ready is high only while idle; the result sits in an output register, and a
// new request is taken while it waits.
module free_list_pool_allocator #(
  parameter int POOL_BYTES   = fla_pkg::POOL_BYTES_DEF,
  parameter int MAX_SEGMENTS = fla_pkg::MAX_SEGMENTS_DEF,
  parameter int MAX_RECORDS  = fla_pkg::MAX_RECORDS_DEF,
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF,
  parameter int NODE_BYTES   = fla_pkg::NODE_BYTES_DEF
) (
  input logic clk,
  input logic rst_n,
  fla_cfg_if.sink   cfg_ch,
  fla_in_if.sink    in_ch,
  fla_out_if.source out_ch
);
  import fla_pkg::*;
  `include "free_list_pool_allocator_assert.svh"

  localparam int SW = $clog2(MAX_SEGMENTS);     // segment index
  localparam int CW = $clog2(MAX_SEGMENTS + 1); // segment count / position
  localparam int RW = $clog2(MAX_RECORDS);      // record index

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_AFIT    = 4'd1;
  localparam logic [3:0] S_ACOMMIT = 4'd2;
  localparam logic [3:0] S_FFIND   = 4'd3;
  localparam logic [3:0] S_FPOS    = 4'd4;
  localparam logic [3:0] S_SHL     = 4'd5;
  localparam logic [3:0] S_SHR     = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  // tables
  logic [15:0] seg_start_r [MAX_SEGMENTS];
  logic [16:0] seg_len_r   [MAX_SEGMENTS];
  logic [15:0] rec_addr_r  [MAX_RECORDS];
  logic [16:0] rec_len_r   [MAX_RECORDS];
  logic [12:0] rec_pad_r   [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] rec_valid_r;

  // control and working registers
  logic [3:0]  state_r, state_nxt;
  logic        policy_r;
  logic [15:0] size_r, size_nxt;
  logic [3:0]  lg_r, lg_nxt;
  logic [15:0] daddr_r, daddr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] found_r, found_nxt;
  logic        found_v_r, found_v_nxt;
  logic [12:0] pad_r, pad_nxt;
  logic [16:0] best_r, best_nxt;
  logic [RW-1:0] slot_r, slot_nxt;
  logic [RW-1:0] rr_r, rr_nxt;
  logic [15:0] fs_r, fs_nxt;
  logic [16:0] flen_r, flen_nxt;
  logic [16:0] prev_end_r, prev_end_nxt;
  logic [16:0] prev_len_r, prev_len_nxt;
  logic [16:0] used_r, used_nxt;
  logic [16:0] peak_r, peak_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r;
  logic [15:0] out_addr_r;
  logic [16:0] out_used_r, out_peak_r;
  logic        out_load;

  // segment table read and write port
  logic [CW-1:0] rd_idx;
  logic [15:0]   rd_start;
  logic [16:0]   rd_len;
  logic          seg_we_start, seg_we_len;
  logic [SW-1:0] seg_wa;
  logic [15:0]   seg_ws;
  logic [16:0]   seg_wl;
  logic          pool_clear;

  // record port
  logic          rec_we, rec_clr;
  logic [15:0]   rec_wa_data;
  logic [16:0]   rec_wl;
  logic [RW-1:0] free_slot;
  logic          free_any;

  // fit evaluator
  logic        fit;
  logic [12:0] fit_pad;
  logic [16:0] fit_diff;

  // working values
  logic [16:0] need;
  logic [16:0] rest;
  logic        join_next, join_prev;
  logic [SW-1:0] pm1;
  logic        in_xfer;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign rd_start = (rd_idx < CW'(MAX_SEGMENTS)) ? seg_start_r[rd_idx[SW-1:0]] : '0;
  assign rd_len   = (rd_idx < CW'(MAX_SEGMENTS)) ? seg_len_r[rd_idx[SW-1:0]]   : '0;

  fla_fit_unit #(.HEADER_BYTES(HEADER_BYTES)) u_fit (
    .seg_start (rd_start),
    .seg_len   (rd_len),
    .size      (size_r),
    .lg        (lg_r),
    .fit       (fit),
    .pad       (fit_pad),
    .diff      (fit_diff)
  );

  // lowest free record slot
  always_comb begin
    free_slot = '0;
    for (int k = MAX_RECORDS - 1; k >= 0; k--) begin
      if (!rec_valid_r[k]) begin
        free_slot = RW'(k);
      end
    end
    free_any = ~&rec_valid_r;
  end

  assign need      = 17'(size_r) + 17'(pad_r);
  assign rest      = rd_len - need;
  assign join_next = (idx_r < count_r) && ((17'(fs_r) + flen_r) == 17'(rd_start));
  assign join_prev = (idx_r != '0) && (prev_end_r == 17'(fs_r));
  assign pm1       = SW'(idx_r - CW'(1));

  always_comb begin
    state_nxt    = state_r;
    size_nxt     = size_r;
    lg_nxt       = lg_r;
    daddr_nxt    = daddr_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    found_nxt    = found_r;
    found_v_nxt  = found_v_r;
    pad_nxt      = pad_r;
    best_nxt     = best_r;
    slot_nxt     = slot_r;
    rr_nxt       = rr_r;
    fs_nxt       = fs_r;
    flen_nxt     = flen_r;
    prev_end_nxt = prev_end_r;
    prev_len_nxt = prev_len_r;
    used_nxt     = used_r;
    peak_nxt     = peak_r;
    status_nxt   = status_r;
    addr_nxt     = addr_r;
    rd_idx       = idx_r;
    seg_we_start = 1'b0;
    seg_we_len   = 1'b0;
    seg_wa       = '0;
    seg_ws       = '0;
    seg_wl       = '0;
    pool_clear   = 1'b0;
    rec_we       = 1'b0;
    rec_clr      = 1'b0;
    rec_wa_data  = '0;
    rec_wl       = '0;
    out_load     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          size_nxt  = in_ch.request_size;
          lg_nxt    = in_ch.align_log2;
          daddr_nxt = in_ch.data_address;
          addr_nxt  = '0;
          state_nxt = S_DONE;
          case (in_ch.opcode)
            OP_ALLOC: begin
              if (in_ch.request_size <= 16'(NODE_BYTES) ||
                  in_ch.align_log2 < 4'(MIN_ALIGN_LOG2) ||
                  in_ch.align_log2 > 4'(MAX_ALIGN_LOG2)) begin
                status_nxt = ST_BAD;
              end else if (!free_any) begin
                status_nxt = ST_FULL;
              end else begin
                slot_nxt    = free_slot;
                idx_nxt     = '0;
                found_v_nxt = 1'b0;
                state_nxt   = S_AFIT;
              end
            end
            OP_FREE: begin
              rr_nxt    = '0;
              state_nxt = S_FFIND;
            end
            OP_RESET: begin
              pool_clear = 1'b1;
              count_nxt  = CW'(1);
              used_nxt   = '0;
              peak_nxt   = '0;
              status_nxt = ST_OK;
            end
            default: begin
              status_nxt = ST_BAD;
            end
          endcase
        end
      end

      S_AFIT: begin
        rd_idx = idx_r;
        if (idx_r < count_r) begin
          idx_nxt = idx_r + CW'(1);
          if (fit) begin
            if (!policy_r) begin
              found_nxt   = idx_r;
              pad_nxt     = fit_pad;
              found_v_nxt = 1'b1;
              state_nxt   = S_ACOMMIT;
            end else if (!found_v_r || fit_diff < best_r) begin
              found_nxt   = idx_r;
              pad_nxt     = fit_pad;
              best_nxt    = fit_diff;
              found_v_nxt = 1'b1;
            end
          end
        end else if (found_v_r) begin
          state_nxt = S_ACOMMIT;
        end else begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_DONE;
        end
      end

      S_ACOMMIT: begin
        rd_idx      = found_r;
        rec_we      = 1'b1;
        rec_wa_data = rd_start + 16'(pad_r);
        rec_wl      = need;
        used_nxt    = used_r + need;
        peak_nxt    = (used_nxt > peak_r) ? used_nxt : peak_r;
        addr_nxt    = rd_start + 16'(pad_r);
        status_nxt  = ST_OK;
        if (rest != '0) begin
          seg_we_start = 1'b1;
          seg_we_len   = 1'b1;
          seg_wa       = found_r[SW-1:0];
          seg_ws       = rd_start + need[15:0];
          seg_wl       = rest;
          state_nxt    = S_DONE;
        end else begin
          j_nxt     = found_r;
          state_nxt = S_SHL;
        end
      end

      // remove entry j: pull later entries down one a cycle
      S_SHL: begin
        rd_idx = j_r + CW'(1);
        if ((j_r + CW'(1)) < count_r) begin
          seg_we_start = 1'b1;
          seg_we_len   = 1'b1;
          seg_wa       = j_r[SW-1:0];
          seg_ws       = rd_start;
          seg_wl       = rd_len;
          j_nxt        = j_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_FFIND: begin
        if (rec_valid_r[rr_r] && rec_addr_r[rr_r] == daddr_r) begin
          slot_nxt  = rr_r;
          fs_nxt    = rec_addr_r[rr_r] - 16'(rec_pad_r[rr_r]);
          flen_nxt  = rec_len_r[rr_r];
          idx_nxt   = '0;
          state_nxt = S_FPOS;
        end else if (rr_r == RW'(MAX_RECORDS - 1)) begin
          status_nxt = ST_UNKNOWN;
          state_nxt  = S_DONE;
        end else begin
          rr_nxt = rr_r + RW'(1);
        end
      end

      S_FPOS: begin
        rd_idx = idx_r;
        if (idx_r < count_r && rd_start < fs_r) begin
          prev_end_nxt = 17'(rd_start) + rd_len;
          prev_len_nxt = rd_len;
          idx_nxt      = idx_r + CW'(1);
        end else if (!join_prev && !join_next && count_r == CW'(MAX_SEGMENTS)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          // region goes back: drop the record and the bytes
          rec_clr    = 1'b1;
          used_nxt   = (flen_r > used_r) ? '0 : used_r - flen_r;
          status_nxt = ST_OK;
          if (join_prev && join_next) begin
            seg_we_len = 1'b1;
            seg_wa     = pm1;
            seg_wl     = prev_len_r + flen_r + rd_len;
            j_nxt      = idx_r;
            state_nxt  = S_SHL;
          end else if (join_prev) begin
            seg_we_len = 1'b1;
            seg_wa     = pm1;
            seg_wl     = prev_len_r + flen_r;
            state_nxt  = S_DONE;
          end else if (join_next) begin
            seg_we_start = 1'b1;
            seg_we_len   = 1'b1;
            seg_wa       = idx_r[SW-1:0];
            seg_ws       = fs_r;
            seg_wl       = rd_len + flen_r;
            state_nxt    = S_DONE;
          end else begin
            j_nxt     = count_r;
            state_nxt = S_SHR;
          end
        end
      end

      // open a hole at idx: push entries up one a cycle, then fill it
      S_SHR: begin
        rd_idx = j_r - CW'(1);
        seg_we_start = 1'b1;
        seg_we_len   = 1'b1;
        if (j_r > idx_r) begin
          seg_wa = j_r[SW-1:0];
          seg_ws = rd_start;
          seg_wl = rd_len;
          j_nxt  = j_r - CW'(1);
        end else begin
          seg_wa    = idx_r[SW-1:0];
          seg_ws    = fs_r;
          seg_wl    = flen_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= 1'b0;
      count_r     <= CW'(1);
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      rec_valid_r <= '0;
      found_v_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
      found_v_r   <= found_v_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        policy_r <= cfg_ch.data;
      end
      if (pool_clear) begin
        rec_valid_r <= '0;
      end else if (rec_we) begin
        rec_valid_r[slot_r] <= 1'b1;
      end else if (rec_clr) begin
        rec_valid_r[slot_r] <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    lg_r       <= lg_nxt;
    daddr_r    <= daddr_nxt;
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    found_r    <= found_nxt;
    pad_r      <= pad_nxt;
    best_r     <= best_nxt;
    slot_r     <= slot_nxt;
    rr_r       <= rr_nxt;
    fs_r       <= fs_nxt;
    flen_r     <= flen_nxt;
    prev_end_r <= prev_end_nxt;
    prev_len_r <= prev_len_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_addr_r   <= addr_r;
      out_used_r   <= used_r;
      out_peak_r   <= peak_r;
    end
  end

  // segment table; reset and pool reset restore one whole segment at entry 0
  always_ff @(posedge clk) begin
    if (!rst_n || pool_clear) begin
      seg_start_r[0] <= '0;
      seg_len_r[0]   <= 17'(POOL_BYTES);
    end else begin
      if (seg_we_start) begin
        seg_start_r[seg_wa] <= seg_ws;
      end
      if (seg_we_len) begin
        seg_len_r[seg_wa] <= seg_wl;
      end
    end
  end

  // record table
  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_addr_r[slot_r] <= rec_wa_data;
      rec_len_r[slot_r]  <= rec_wl;
      rec_pad_r[slot_r]  <= pad_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.used_bytes     = out_used_r;
  assign out_ch.peak_bytes     = out_peak_r;

  `FLA_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(MAX_SEGMENTS))
  `FLA_ASSERT_SAME(a_used_le_peak, clk, rst_n, out_valid_r, out_used_r <= out_peak_r)
  `FLA_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, state_r != S_IDLE)
endmodule

// ----- rtl/fla_fit_unit.sv -----
// Fit evaluator: padding, needed bytes and leftover for one free segment.
module fla_fit_unit #(
  parameter int HEADER_BYTES = fla_pkg::HEADER_BYTES_DEF
) (
  input  logic [15:0] seg_start,
  input  logic [16:0] seg_len,
  input  logic [15:0] size,
  input  logic [3:0]  lg,
  output logic        fit,
  output logic [12:0] pad,
  output logic [16:0] diff
);
  logic [16:0] hdr_end;
  logic [16:0] mask;
  logic [16:0] pad_w;
  logic [16:0] need;

  assign hdr_end = 17'(seg_start) + 17'(HEADER_BYTES);
  assign mask    = (17'd1 << lg) - 17'd1;
  assign pad_w   = 17'(HEADER_BYTES) + ((~hdr_end + 17'd1) & mask);
  assign pad     = pad_w[12:0];
  assign need    = 17'(size) + pad_w;
  assign fit     = seg_len >= need;
  assign diff    = seg_len - need;
endmodule
